/* rtl/core/iso_timestamp_dst_parser_defines.svh */
// Assertion macros for the timestamp parser.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ISO_TIMESTAMP_DST_PARSER_DEFINES_SVH
`define ISO_TIMESTAMP_DST_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITDP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/itdp_pkg.sv */
// Shared types, constants and lookup functions for the timestamp parser.
// Depends on nothing; every other file of the block but the defines header imports it.
package itdp_pkg;

  localparam int YEAR_W     = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_YEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_YEAR = 2'd1;

  localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd2000;
  localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2099;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_BASE      = 3'd0,
    PH_AFTER_SEC = 3'd1,
    PH_MS        = 3'd2,
    PH_AFTER_MS  = 3'd3,
    PH_AFTER_Z   = 3'd4,
    PH_PREFIX    = 3'd5,
    PH_DIGIT     = 3'd6,
    PH_DONE      = 3'd7
  } phase_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       last_char;
  } char_beat_t;

  typedef struct packed {
    logic              valid_res;
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
    logic [9:0]        millis;
    logic              dst_given;
    logic              dst_on;
  } res_beat_t;

  // Days in a month for a common year; the caller handles February of leap years.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:    len = 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Characters of the DST keyword that follows the semicolon.
  function automatic logic [7:0] dst_char(input logic [1:0] i);
    logic [7:0] ch;
    case (i)
      2'd0:    ch = 8'h44;
      2'd1:    ch = 8'h53;
      2'd2:    ch = 8'h54;
      default: ch = 8'h3D;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/iso_timestamp_dst_parser.sv */
// Top level of the timestamp parser: character scanner, check stage and result register.
// Depends on itdp_pkg and on iso_timestamp_dst_parser_defines.svh for assertions.
//
// The char channel carries one character of the timestamp string per beat, with
// last_char set on the final character. Non-final characters produce no result.
// The final character produces one result beat on the res channel: a valid flag
// and the parsed date, time, milliseconds and DST suffix, all zero when invalid.
// Every character is scanned in the cycle it is accepted, so one character can be
// taken per cycle while char_stall is low. After the final character is taken, its
// result is registered in a check stage, then moves to the result register behind
// res_valid, so the next string can start right away. The limit on rate is the
// single check stage between the scanner and the result register: while a result
// waits in it because the result register is stalled, char_stall is high.
// Reset clears the scanner and both stages and loads the year window with
// 2000 to 2099. The year window is written through cfg_we, cfg_index and cfg_data.
// The user must write it only while the block is idle; the block does not enforce
// this. Indexes above 1 are ignored. A stalled result holds its value until taken.
`include "iso_timestamp_dst_parser_defines.svh"

module iso_timestamp_dst_parser (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               char_valid,
  output logic                               char_stall,
  input  itdp_pkg::char_beat_t               char_beat,
  output logic                               res_valid,
  input  logic                               res_stall,
  output itdp_pkg::res_beat_t                res_beat,
  input  logic                               cfg_we,
  input  logic [itdp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [itdp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import itdp_pkg::*;

  typedef struct packed {
    logic [4:0]        position;
    logic              bad;
    logic [YEAR_W-1:0] year_acc;
    logic [6:0]        year_hi;
    logic [6:0]        year_lo;
    logic [6:0]        month_acc;
    logic [6:0]        day_acc;
    logic [6:0]        hour_acc;
    logic [6:0]        minute_acc;
    logic [6:0]        second_acc;
    logic [9:0]        millis_acc;
    phase_t            phase;
    logic [1:0]        dst_bits;
  } scan_t;

  localparam scan_t SCAN_RST = '{
    position:   5'd0,
    bad:        1'b0,
    year_acc:   '0,
    year_hi:    7'd0,
    year_lo:    7'd0,
    month_acc:  7'd0,
    day_acc:    7'd0,
    hour_acc:   7'd0,
    minute_acc: 7'd0,
    second_acc: 7'd0,
    millis_acc: 10'd0,
    phase:      PH_BASE,
    dst_bits:   2'd0
  };

  function automatic logic [6:0] add7(input logic [6:0] acc, input logic [3:0] d);
    return 7'(acc * 7'd10 + 7'(d));
  endfunction

  logic [YEAR_W-1:0] min_year;
  logic [YEAR_W-1:0] max_year;
  scan_t             scan;
  scan_t             scan_next;
  scan_t             held;
  logic              held_valid;
  logic              char_take;
  logic              held_move;
  logic [7:0]        c;
  logic              dig;
  logic [3:0]        d;
  logic              leap;
  logic [4:0]        max_day;
  logic              ok;
  res_beat_t         res_next;

  assign char_stall = held_valid && res_valid && res_stall;
  assign char_take  = char_valid && !char_stall;
  assign held_move  = held_valid && (!res_valid || !res_stall);

  assign c   = char_beat.char_in;
  assign dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign d   = dig ? c[3:0] : 4'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RST;
      max_year <= MAX_YEAR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_YEAR: min_year <= cfg_data;
        REG_MAX_YEAR: max_year <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    scan_next = scan;
    if (scan.position != 5'd31) begin
      scan_next.position = scan.position + 5'd1;
    end
    if (!scan.bad) begin
      if (scan.position == 5'd31) begin
        scan_next.bad = 1'b1;
      end else begin
        case (scan.phase)
          PH_BASE: begin
            if (scan.position == 5'd4 || scan.position == 5'd7) begin
              if (c != CH_DASH) scan_next.bad = 1'b1;
            end else if (scan.position == 5'd10) begin
              if (c != CH_T) scan_next.bad = 1'b1;
            end else if (scan.position == 5'd13 || scan.position == 5'd16) begin
              if (c != CH_COLON) scan_next.bad = 1'b1;
            end else if (!dig) begin
              scan_next.bad = 1'b1;
            end else if (scan.position <= 5'd3) begin
              scan_next.year_acc = YEAR_W'(scan.year_acc * 14'd10 + 14'(d));
              if (scan.position <= 5'd1) begin
                scan_next.year_hi = add7(scan.year_hi, d);
              end else begin
                scan_next.year_lo = add7(scan.year_lo, d);
              end
            end else if (scan.position <= 5'd6) begin
              scan_next.month_acc = add7(scan.month_acc, d);
            end else if (scan.position <= 5'd9) begin
              scan_next.day_acc = add7(scan.day_acc, d);
            end else if (scan.position <= 5'd12) begin
              scan_next.hour_acc = add7(scan.hour_acc, d);
            end else if (scan.position <= 5'd15) begin
              scan_next.minute_acc = add7(scan.minute_acc, d);
            end else begin
              scan_next.second_acc = add7(scan.second_acc, d);
            end
            if (scan.position >= 5'd18) scan_next.phase = PH_AFTER_SEC;
          end
          PH_AFTER_SEC: begin
            if (c == CH_DOT) begin
              scan_next.phase = PH_MS;
            end else if (c == CH_Z) begin
              scan_next.phase = PH_AFTER_Z;
            end else if (c == CH_SEMI) begin
              scan_next.phase    = PH_PREFIX;
              scan_next.dst_bits = 2'd0;
            end else begin
              scan_next.bad = 1'b1;
            end
          end
          PH_MS: begin
            if (dig) begin
              scan_next.millis_acc = 10'(scan.millis_acc * 10'd10 + 10'(d));
              if (scan.position >= 5'd22) scan_next.phase = PH_AFTER_MS;
            end else begin
              scan_next.bad = 1'b1;
            end
          end
          PH_AFTER_MS: begin
            if (c == CH_Z) begin
              scan_next.phase = PH_AFTER_Z;
            end else if (c == CH_SEMI) begin
              scan_next.phase    = PH_PREFIX;
              scan_next.dst_bits = 2'd0;
            end else begin
              scan_next.bad = 1'b1;
            end
          end
          PH_AFTER_Z: begin
            if (c == CH_SEMI) begin
              scan_next.phase    = PH_PREFIX;
              scan_next.dst_bits = 2'd0;
            end else begin
              scan_next.bad = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (c == dst_char(scan.dst_bits)) begin
              if (scan.dst_bits == 2'd3) begin
                scan_next.phase    = PH_DIGIT;
                scan_next.dst_bits = 2'd0;
              end else begin
                scan_next.dst_bits = scan.dst_bits + 2'd1;
              end
            end else begin
              scan_next.bad = 1'b1;
            end
          end
          PH_DIGIT: begin
            if (c == CH_ZERO || c == CH_ONE) begin
              scan_next.dst_bits = {c == CH_ONE, 1'b1};
              scan_next.phase    = PH_DONE;
            end else begin
              scan_next.bad = 1'b1;
            end
          end
          default: begin
            scan_next.bad = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan       <= SCAN_RST;
      held_valid <= 1'b0;
    end else begin
      if (char_take) begin
        scan <= char_beat.last_char ? SCAN_RST : scan_next;
      end
      if (char_take && char_beat.last_char) begin
        held_valid <= 1'b1;
      end else if (held_move) begin
        held_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_take && char_beat.last_char) begin
      held <= scan_next;
    end
  end

  // A year divisible by 100 is leap only when its upper two digits are divisible by 4.
  assign leap = (held.year_lo == 7'd0) ? (held.year_hi[1:0] == 2'd0)
                                       : (held.year_lo[1:0] == 2'd0);

  always_comb begin
    max_day = month_len(held.month_acc[3:0]);
    if (held.month_acc == 7'd2 && leap) max_day = 5'd29;
    ok = !held.bad &&
         (held.phase == PH_AFTER_SEC || held.phase == PH_AFTER_MS ||
          held.phase == PH_AFTER_Z || held.phase == PH_DONE) &&
         held.year_acc >= min_year && held.year_acc <= max_year &&
         held.month_acc >= 7'd1 && held.month_acc <= 7'd12 &&
         held.day_acc >= 7'd1 && held.day_acc <= {2'b00, max_day} &&
         held.hour_acc <= 7'd23 && held.minute_acc <= 7'd59 &&
         held.second_acc <= 7'd59;
    res_next = '0;
    if (ok) begin
      res_next.valid_res = 1'b1;
      res_next.year      = held.year_acc;
      res_next.month     = held.month_acc[3:0];
      res_next.day       = held.day_acc[4:0];
      res_next.hour      = held.hour_acc[4:0];
      res_next.minute    = held.minute_acc[5:0];
      res_next.second    = held.second_acc[5:0];
      res_next.millis    = held.millis_acc;
      if (held.phase == PH_DONE) begin
        res_next.dst_given = held.dst_bits[0];
        res_next.dst_on    = held.dst_bits[1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (held_move) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (held_move) begin
      res_beat <= res_next;
    end
  end

  `ITDP_ASSERT_NEXT(a_last_held, char_take && char_beat.last_char, held_valid,
    "final character was not captured for checking")
  `ITDP_ASSERT_NEXT(a_last_clears, char_take && char_beat.last_char,
    scan.position == 5'd0 && !scan.bad && scan.phase == PH_BASE,
    "scanner did not restart after the final character")
  `ITDP_ASSERT_NEXT(a_held_moves, held_valid && !res_valid, res_valid,
    "checked result did not reach the result register")
  `ITDP_ASSERT_SAME(a_invalid_zero, res_valid && !res_beat.valid_res,
    res_beat.year == '0 && res_beat.month == 4'd0 && res_beat.day == 5'd0 &&
    res_beat.millis == 10'd0 && !res_beat.dst_given && !res_beat.dst_on,
    "invalid result carries nonzero fields")
  `ITDP_ASSERT_SAME(a_dst_given, res_valid && res_beat.dst_on, res_beat.dst_given,
    "DST digit reported without a DST suffix")

endmodule

/* tb/sv/iso_timestamp_dst_parser_chk.sv */
`timescale 1ns / 100ps
// Checker for the timestamp parser: follows the year window writes, predicts one result
// per final character and compares every accepted result beat field by field.
// Depends on itdp_pkg for the beat types, scan phases and character constants.
module iso_timestamp_dst_parser_chk
  import itdp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  input  logic                  char_stall,
  input  char_beat_t            char_beat,
  input  logic                  res_valid,
  input  logic                  res_stall,
  input  res_beat_t             res_beat,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    n_due
);

  localparam logic [31:0] DST_WORD = "DST=";

  logic [4:0]        scan_pos;
  logic              scan_bad;
  logic [13:0]       yr_acc;
  logic [6:0]        mo_acc;
  logic [6:0]        dy_acc;
  logic [6:0]        hr_acc;
  logic [6:0]        mi_acc;
  logic [6:0]        se_acc;
  logic [9:0]        ms_acc;
  phase_t            scan_ph;
  logic [1:0]        kw_bits;
  logic [YEAR_W-1:0] lo_year;
  logic [YEAR_W-1:0] hi_year;
  res_beat_t         due_q[$];

  task automatic clear_scan();
    scan_pos = '0;
    scan_bad = 1'b0;
    yr_acc   = '0;
    mo_acc   = '0;
    dy_acc   = '0;
    hr_acc   = '0;
    mi_acc   = '0;
    se_acc   = '0;
    ms_acc   = '0;
    scan_ph  = PH_BASE;
    kw_bits  = '0;
  endtask

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic scan_base(input int idx, input logic [7:0] c);
    int d;
    d = c - CH_ZERO;
    if (idx == 4 || idx == 7) begin
      if (c != CH_DASH) scan_bad = 1'b1;
    end else if (idx == 10) begin
      if (c != CH_T) scan_bad = 1'b1;
    end else if (idx == 13 || idx == 16) begin
      if (c != CH_COLON) scan_bad = 1'b1;
    end else if (!is_digit(c)) begin
      scan_bad = 1'b1;
    end else if (idx <= 3) begin
      yr_acc = 14'(yr_acc * 10 + d);
    end else if (idx <= 6) begin
      mo_acc = 7'(mo_acc * 10 + d);
    end else if (idx <= 9) begin
      dy_acc = 7'(dy_acc * 10 + d);
    end else if (idx <= 12) begin
      hr_acc = 7'(hr_acc * 10 + d);
    end else if (idx <= 15) begin
      mi_acc = 7'(mi_acc * 10 + d);
    end else begin
      se_acc = 7'(se_acc * 10 + d);
    end
    if (idx >= 18) scan_ph = PH_AFTER_SEC;
  endtask

  task automatic scan_char(input int idx, input logic [7:0] c);
    if (idx >= 31) begin
      scan_bad = 1'b1;
    end else begin
      case (scan_ph)
        PH_BASE: scan_base(idx, c);
        PH_AFTER_SEC: begin
          if (c == CH_DOT) scan_ph = PH_MS;
          else if (c == CH_Z) scan_ph = PH_AFTER_Z;
          else if (c == CH_SEMI) begin
            scan_ph = PH_PREFIX;
            kw_bits = '0;
          end else scan_bad = 1'b1;
        end
        PH_MS: begin
          if (is_digit(c)) begin
            ms_acc = 10'(ms_acc * 10 + (c - CH_ZERO));
            if (idx >= 22) scan_ph = PH_AFTER_MS;
          end else scan_bad = 1'b1;
        end
        PH_AFTER_MS: begin
          if (c == CH_Z) scan_ph = PH_AFTER_Z;
          else if (c == CH_SEMI) begin
            scan_ph = PH_PREFIX;
            kw_bits = '0;
          end else scan_bad = 1'b1;
        end
        PH_AFTER_Z: begin
          if (c == CH_SEMI) begin
            scan_ph = PH_PREFIX;
            kw_bits = '0;
          end else scan_bad = 1'b1;
        end
        PH_PREFIX: begin
          if (c == DST_WORD[8 * (3 - kw_bits) +: 8]) begin
            if (kw_bits == 2'd3) begin
              scan_ph = PH_DIGIT;
              kw_bits = '0;
            end else kw_bits = kw_bits + 2'd1;
          end else scan_bad = 1'b1;
        end
        PH_DIGIT: begin
          if (c == CH_ZERO || c == CH_ONE) begin
            kw_bits = {c == CH_ONE, 1'b1};
            scan_ph = PH_DONE;
          end else scan_bad = 1'b1;
        end
        default: scan_bad = 1'b1;
      endcase
    end
  endtask

  function automatic logic stamp_ok();
    int   cap;
    logic leap;
    if (yr_acc < lo_year || yr_acc > hi_year) return 1'b0;
    if (mo_acc < 1 || mo_acc > 12) return 1'b0;
    leap = (yr_acc % 4 == 0 && yr_acc % 100 != 0) || yr_acc % 400 == 0;
    case (mo_acc)
      2:             cap = leap ? 29 : 28;
      4, 6, 9, 11:   cap = 30;
      default:       cap = 31;
    endcase
    return dy_acc >= 1 && dy_acc <= cap && hr_acc <= 23 && mi_acc <= 59 && se_acc <= 59;
  endfunction

  task automatic take_beat(input char_beat_t b);
    int        idx;
    logic      ok;
    res_beat_t r;
    idx = int'(scan_pos);
    if (scan_pos < 5'd31) scan_pos = scan_pos + 5'd1;
    if (!scan_bad) scan_char(idx, b.char_in);
    if (b.last_char) begin
      r  = '0;
      ok = !scan_bad && (scan_ph == PH_AFTER_SEC || scan_ph == PH_AFTER_MS ||
                         scan_ph == PH_AFTER_Z || scan_ph == PH_DONE) && stamp_ok();
      if (ok) begin
        r.valid_res = 1'b1;
        r.year      = yr_acc;
        r.month     = mo_acc[3:0];
        r.day       = dy_acc[4:0];
        r.hour      = hr_acc[4:0];
        r.minute    = mi_acc[5:0];
        r.second    = se_acc[5:0];
        r.millis    = ms_acc;
        if (scan_ph == PH_DONE) begin
          r.dst_given = kw_bits[0];
          r.dst_on    = kw_bits[1];
        end
      end
      due_q.push_back(r);
      clear_scan();
    end
  endtask

  task automatic check_field(input string tag, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d actual %0d", $time, tag, want, got);
    end
  endtask

  task automatic check_result(input res_beat_t got);
    res_beat_t want;
    if (due_q.size() == 0) begin
      fail_count++;
      $display("%0t: result beat expected none actual %h", $time, got);
    end else begin
      want = due_q.pop_front();
      check_field("valid_res", want.valid_res, got.valid_res);
      check_field("year", want.year, got.year);
      check_field("month", want.month, got.month);
      check_field("day", want.day, got.day);
      check_field("hour", want.hour, got.hour);
      check_field("minute", want.minute, got.minute);
      check_field("second", want.second, got.second);
      check_field("millis", want.millis, got.millis);
      check_field("dst_given", want.dst_given, got.dst_given);
      check_field("dst_on", want.dst_on, got.dst_on);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_scan();
      lo_year    = MIN_YEAR_RST;
      hi_year    = MAX_YEAR_RST;
      fail_count = 0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_YEAR: lo_year = cfg_data;
          REG_MAX_YEAR: hi_year = cfg_data;
          default: ;
        endcase
      end
      if (char_valid && !char_stall) take_beat(char_beat);
      if (res_valid && !res_stall) check_result(res_beat);
    end
    n_due = due_q.size();
  end

endmodule

/* tb/sv/iso_timestamp_dst_parser_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the timestamp parser: clock, reset, year window writes and
// character stimulus under several idle and stall mixes; gives the final verdict.
// Depends on itdp_pkg, the parser RTL and iso_timestamp_dst_parser_chk.
module iso_timestamp_dst_parser_tb;
  import itdp_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASES          = 8;
  localparam int CHARS_PER_PHASE = 90;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  char_valid;
  logic                  char_stall;
  char_beat_t            char_beat;
  logic                  res_valid;
  logic                  res_stall;
  res_beat_t             res_beat;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int         fails;
  int         n_due;
  int         idle_pct  = 0;
  int         stall_pct = 0;
  int         cycles    = 0;
  int         sent      = 0;
  int         win_lo    = 2000;
  int         win_hi    = 2099;
  logic [7:0] msg_q[$];

  iso_timestamp_dst_parser u_dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_beat   (res_beat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  iso_timestamp_dst_parser_chk u_chk (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_beat  (char_beat),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_beat   (res_beat),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fails),
    .n_due      (n_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    res_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic push_char(input logic [7:0] c, input logic lst);
    char_beat_t b;
    b.char_in   = c;
    b.last_char = lst;
    while ($urandom_range(99) < idle_pct) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_beat  <= b;
    do @(posedge clk); while (char_stall);
    @(negedge clk);
  endtask

  task automatic send_msg();
    for (int i = 0; i < msg_q.size(); i++) push_char(msg_q[i], i == msg_q.size() - 1);
    sent += msg_q.size();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
  endtask

  task automatic put_num(input int v, input int n);
    for (int k = n - 1; k >= 0; k--) begin
      msg_q.push_back(8'(int'(CH_ZERO) + (v / (10 ** k)) % 10));
    end
  endtask

  task automatic send_text(input string s);
    msg_q.delete();
    put_str(s);
    send_msg();
  endtask

  function automatic int pick(input int lo, input int hi, input int pct);
    return ($urandom_range(99) < pct) ? $urandom_range(hi, lo) : $urandom_range(99);
  endfunction

  task automatic build_stamp();
    int yr;
    int mo;
    int dy;
    int hi_clip;
    int r;
    hi_clip = (win_hi > 9999) ? 9999 : win_hi;
    if ($urandom_range(99) < 55 && win_lo <= hi_clip) begin
      yr = $urandom_range(hi_clip, win_lo);
    end else if ($urandom_range(99) < 35) begin
      case ($urandom_range(4))
        0:       yr = 1600;
        1:       yr = 1900;
        2:       yr = 2000;
        3:       yr = 2100;
        default: yr = 2400;
      endcase
    end else begin
      yr = $urandom_range(9999);
    end
    mo = pick(1, 12, 88);
    if (mo == 2 && $urandom_range(99) < 50) dy = $urandom_range(29, 28);
    else dy = pick(1, 31, 85);
    msg_q.delete();
    put_num(yr, 4);
    put_str("-");
    put_num(mo, 2);
    put_str("-");
    put_num(dy, 2);
    put_str("T");
    put_num(pick(0, 23, 90), 2);
    put_str(":");
    put_num(pick(0, 59, 90), 2);
    put_str(":");
    put_num(pick(0, 59, 90), 2);
    if ($urandom_range(1)) begin
      put_str(".");
      put_num($urandom_range(999), 3);
    end
    if ($urandom_range(1)) put_str("Z");
    r = $urandom_range(9);
    if (r >= 7) put_str(";DST=1");
    else if (r >= 4) put_str(";DST=0");
  endtask

  // Mostly well-formed stamps; the rest are corrupted, cut short, overlong or pure noise.
  task automatic random_line();
    int kind;
    int keep;
    build_stamp();
    kind = $urandom_range(99);
    if (kind < 12) begin
      msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
    end else if (kind < 20) begin
      keep = $urandom_range(msg_q.size() - 1, 1);
      while (msg_q.size() > keep) void'(msg_q.pop_back());
    end else if (kind < 25) begin
      repeat ($urandom_range(12, 1)) msg_q.push_back(8'($urandom_range(255)));
    end else if (kind < 30) begin
      msg_q.delete();
      repeat ($urandom_range(40, 1)) msg_q.push_back(8'($urandom_range(255)));
    end
    send_msg();
  endtask

  // The block is idle once every result has come and the check stage has emptied.
  task automatic drain();
    char_valid <= 1'b0;
    while (n_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_window(input int lo, input int hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_YEAR;
    cfg_data  <= CFG_DATA_W'(lo);
    @(negedge clk);
    cfg_index <= REG_MAX_YEAR;
    cfg_data  <= CFG_DATA_W'(hi);
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= CFG_DATA_W'($urandom_range(16383));
    @(negedge clk);
    cfg_we <= 1'b0;
    win_lo = lo;
    win_hi = hi;
  endtask

  initial begin
    int lo;
    int hi;
    int target;
    rst        = 1'b1;
    char_valid = 1'b0;
    char_beat  = '0;
    res_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_MIN_YEAR;
    cfg_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_text("2024-02-29T23:59:59.999Z;DST=1");
    send_text("2000-01-01T00:00:00");
    send_text("2099-12-31T23:59:59;DST=0");
    send_text("2023-02-29T12:00:00");
    send_text("1999-06-15T10:10:10Z");
    send_text("2100-01-01T00:00:00");
    send_text("2024-13-01T00:00:00");
    send_text("2024-00-10T00:00:00");
    send_text("2024-04-31T00:00:00");
    send_text("2024-01-00T00:00:00");
    send_text("2024-01-01T24:00:00.000");
    send_text("2024-01-01T00:60:00Z");
    send_text("2024-01-01T00:00:60");
    send_text("2024-01-01T00:00:00.5");
    send_text("2024-01");
    send_text("2024-02-29T23:59:59.999Z;DST=1X");
    send_text("2024-01-01T00:00:00;DST=2");
    send_text("2024-01-01T00:00:00;DSX=1");
    send_text("2024-01-01T00:00:00Z;DST=");
    send_text("2024-01-01T00:00:00.123;DST=0ZZZZZZZZZZZ");
    msg_q.delete();
    put_str("2024-01-01T00:00:00");
    msg_q[13] = 8'h00;
    send_msg();

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: set_window(0, 16383);
          2: set_window(1900, 2400);
          3: set_window(2100, 2000);
          4: set_window(0, 0);
          5: set_window(9999, 9999);
          6: begin
            lo = $urandom_range(9999);
            hi = $urandom_range(9999);
            if (lo > hi) set_window(hi, lo);
            else set_window(lo, hi);
          end
          default: set_window(MIN_YEAR_RST, MAX_YEAR_RST);
        endcase
      end
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      target = sent + CHARS_PER_PHASE;
      while (sent < target) random_line();
    end

    drain();
    if (fails == 0 && n_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
